### rtl/core/ibs_pkg.sv
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared constants and types of the image band statistics core.
// ----------------------------------------------------------------------------
package ibs_pkg;

    localparam int MAX_BANDS        = 4;
    localparam int PIXEL_COUNT_BITS = 20;
    localparam int BINS             = 256;

    localparam int BAND_W = $clog2(MAX_BANDS);
    localparam int BIN_W  = $clog2(BINS);
    localparam int CNT_W  = PIXEL_COUNT_BITS + 1;
    localparam int SUM_W  = CNT_W + 16;
    localparam int ADDR_W = BAND_W + BIN_W;
    localparam int NB_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [SUM_W-1:0] sum_t;

    // floor(s/257) without a divider: s*255 >> 16 with one correction
    function automatic logic [BIN_W-1:0] bin_of(input logic [15:0] s);
        logic [23:0] p;
        logic [8:0]  q;
        logic [24:0] back;
        begin
            p    = {8'd0, s} * 24'd255;
            q    = {1'b0, p[23:16]};
            back = {16'd0, q} * 25'd257;
            if (back + 25'd257 <= {9'd0, s})
                q = q + 9'd1;
            bin_of = q[BIN_W-1:0];
        end
    endfunction

endpackage

### rtl/core/image_band_statistics_core.sv
// ----------------------------------------------------------------------------
// image_band_statistics_core
// Per-band min, max, average, median bin and mode bin of an interleaved stream.
// ----------------------------------------------------------------------------
// Each sample's histogram bin is read when the sample is accepted, then written
// back incremented through the separate write port, so busy is high for the
// write-back after every sample. After the sample flagged last, each band is
// scanned over its 256 histogram bins, one bin per cycle while the bin is also
// cleared, then the average is worked out by a restoring divider of 37 quotient
// steps; one result per band follows on result_valid. The receiver cannot stall.
// After reset, and after every image with fewer than four bands, a clearing pass
// sweeps all 1024 histogram entries with busy high.
module image_band_statistics_core
    import ibs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] sample,
    input  logic        last,
    output logic        result_valid,
    output logic [1:0]  band,
    output logic [15:0] minimum,
    output logic [15:0] maximum,
    output logic [15:0] average,
    output logic [7:0]  median_bin,
    output logic [7:0]  mode_bin,
    output logic        last_band
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam int DIV_STEPS = SUM_W;

    logic [2:0]          state_reg;
    logic [NB_W-1:0]     nb_cfg_reg;
    logic [BAND_W-1:0]   idx_reg;
    logic [15:0]         min_reg [MAX_BANDS];
    logic [15:0]         max_reg [MAX_BANDS];
    sum_t                sum_reg [MAX_BANDS];
    cnt_t                cnt_reg [MAX_BANDS];
    logic                pend_last_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic                hist_inc_reg;

    // scan state
    logic [BAND_W-1:0]   sb_reg;
    logic [BIN_W:0]      sbin_reg;
    cnt_t                cum_reg;
    cnt_t                best_reg;
    logic [BIN_W-1:0]    med_reg;
    logic [BIN_W-1:0]    mode_reg;
    logic                med_found_reg;
    sum_t                rem_reg;
    sum_t                quo_reg;
    logic [$clog2(DIV_STEPS+1)-1:0] dstep_reg;

    // histogram memory
    cnt_t                mem [MAX_BANDS*BINS];
    cnt_t                rd_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    cnt_t                mem_wdata;
    logic [ADDR_W:0]     clr_reg;

    logic [BAND_W:0]     nb_eff;
    logic [BAND_W-1:0]   b_cur;
    logic                accept;

    // effective band count
    always_comb
    begin
        if (nb_cfg_reg == '0)
            nb_eff = (BAND_W+1)'(1);
        else if (nb_cfg_reg > NB_W'(MAX_BANDS))
            nb_eff = (BAND_W+1)'(MAX_BANDS);
        else
            nb_eff = nb_cfg_reg[BAND_W:0];
    end

    assign b_cur  = ({1'b0, idx_reg} >= nb_eff) ? '0 : idx_reg;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // memory read address
    always_comb
    begin
        if (state_reg == S_SCAN)
            rd_addr = {sb_reg, sbin_reg[BIN_W-1:0]};
        else
            rd_addr = {b_cur, bin_of(sample)};
    end

    // memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rd_data + cnt_t'(1);
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[ADDR_W-1:0];
                mem_wdata = '0;
            end
            S_WRITE:
            begin
                mem_we = hist_inc_reg;
            end
            S_SCAN:
            begin
                mem_we    = (sbin_reg != '0);
                mem_waddr = {sb_reg, sbin_reg[BIN_W-1:0] - BIN_W'(1)};
                mem_wdata = '0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data <= mem[rd_addr];
    end

    // control and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            nb_cfg_reg    <= NB_W'(1);
            idx_reg       <= '0;
            clr_reg       <= '0;
            pend_last_reg <= 1'b0;
            hist_inc_reg  <= 1'b0;
            result_valid  <= 1'b0;
            for (int i = 0; i < MAX_BANDS; i++)
                cnt_reg[i] <= '0;
            sb_reg        <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
                nb_cfg_reg <= cfg_wdata;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (ADDR_W+1)'(MAX_BANDS*BINS-1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        wr_addr_reg   <= {b_cur, bin_of(sample)};
                        pend_last_reg <= last;
                        hist_inc_reg  <= (cnt_reg[b_cur] != CNT_MAX);
                        if (cnt_reg[b_cur] == '0)
                        begin
                            min_reg[b_cur] <= sample;
                            max_reg[b_cur] <= sample;
                        end
                        else
                        begin
                            if (sample < min_reg[b_cur]) min_reg[b_cur] <= sample;
                            if (sample > max_reg[b_cur]) max_reg[b_cur] <= sample;
                        end
                        if (cnt_reg[b_cur] != CNT_MAX)
                        begin
                            cnt_reg[b_cur] <= cnt_reg[b_cur] + cnt_t'(1);
                            sum_reg[b_cur] <= ((cnt_reg[b_cur] == '0) ? '0 : sum_reg[b_cur])
                                              + sum_t'(sample);
                        end
                        idx_reg   <= ({1'b0, b_cur} + 1'b1 >= nb_eff) ? '0 : b_cur + 1'b1;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (pend_last_reg)
                    begin
                        sb_reg        <= '0;
                        sbin_reg      <= '0;
                        cum_reg       <= '0;
                        best_reg      <= '0;
                        med_reg       <= '0;
                        mode_reg      <= '0;
                        med_found_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    // rd_data holds the bin read last cycle
                    sbin_reg <= sbin_reg + 1'b1;
                    if (sbin_reg != '0)
                    begin
                        cum_reg <= cum_reg + rd_data;
                        if (!med_found_reg &&
                            (cum_reg + rd_data) > (cnt_reg[sb_reg] >> 1))
                        begin
                            med_reg       <= sbin_reg[BIN_W-1:0] - BIN_W'(1);
                            med_found_reg <= 1'b1;
                        end
                        if (rd_data > best_reg)
                        begin
                            best_reg <= rd_data;
                            mode_reg <= sbin_reg[BIN_W-1:0] - BIN_W'(1);
                        end
                    end
                    if (sbin_reg == (BIN_W+1)'(BINS))
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= sum_reg[sb_reg];
                        dstep_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring divider, one quotient bit per cycle
                    if (dstep_reg == ($bits(dstep_reg))'(DIV_STEPS))
                        state_reg <= S_EMIT;
                    else
                    begin
                        if ({rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]} >= sum_t'(cnt_reg[sb_reg]))
                        begin
                            rem_reg <= {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]}
                                       - sum_t'(cnt_reg[sb_reg]);
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                        end
                        dstep_reg <= dstep_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    result_valid <= 1'b1;
                    band         <= 2'(sb_reg);
                    last_band    <= ({1'b0, sb_reg} + 1'b1 == nb_eff);
                    if (cnt_reg[sb_reg] == '0)
                    begin
                        minimum    <= '0;
                        maximum    <= '0;
                        average    <= '0;
                        median_bin <= '0;
                        mode_bin   <= '0;
                    end
                    else
                    begin
                        minimum    <= min_reg[sb_reg];
                        maximum    <= max_reg[sb_reg];
                        average    <= quo_reg[15:0];
                        median_bin <= med_reg;
                        mode_bin   <= mode_reg;
                    end
                    if ({1'b0, sb_reg} + 1'b1 == nb_eff)
                    begin
                        for (int i = 0; i < MAX_BANDS; i++)
                            cnt_reg[i] <= '0;
                        idx_reg <= '0;
                        // bins of unreported bands need clearing too
                        clr_reg   <= '0;
                        state_reg <= (nb_eff == (BAND_W+1)'(MAX_BANDS)) ? S_IDLE : S_CLEAR;
                    end
                    else
                    begin
                        sb_reg        <= sb_reg + 1'b1;
                        sbin_reg      <= '0;
                        cum_reg       <= '0;
                        best_reg      <= '0;
                        med_reg       <= '0;
                        mode_reg      <= '0;
                        med_found_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
